@@ design/four_level_page_table_manager_defines.svh @@
// Assertion macros for the four-level page table manager.
// Used by the port checker; they assume signals named clk and rst in scope.
`ifndef FOUR_LEVEL_PAGE_TABLE_MANAGER_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_MANAGER_DEFINES_SVH

// Property checked on every rising edge outside reset.
`define PTM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define PTM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/ptm_pkg.sv @@
// Shared types, codes and sizes for the four-level page table manager.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ptm_pkg;

  localparam int TABLE_FRAMES = 64;
  localparam int IDX_W        = 9;
  localparam int FRAME_W      = $clog2(TABLE_FRAMES);
  localparam int STORE_DEPTH  = TABLE_FRAMES * (1 << IDX_W);
  localparam int STORE_AW     = FRAME_W + IDX_W;
  localparam int NF_W         = 11;
  localparam int VA_W         = 48;
  localparam int PA_W         = 52;
  localparam int PFN_W        = 40;
  localparam int ENTRY_W      = 64;
  localparam int OFF_W        = 12;
  localparam int IN_DATA_W    = 168;
  localparam int OUT_DATA_W   = 56;

  localparam int BIT_PRESENT = 0;
  localparam int BIT_WRITE   = 1;
  localparam int BIT_USER    = 2;

  typedef enum logic [1:0] {
    ACT_MAP   = 2'd0,
    ACT_UNMAP = 2'd1,
    ACT_XLATE = 2'd2,
    ACT_NONE  = 2'd3
  } ptm_action_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NOMEM    = 2'd1,
    STAT_MAPPED   = 2'd2,
    STAT_UNMAPPED = 2'd3
  } ptm_status_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_ZERO,
    ST_LINK,
    ST_DONE
  } ptm_state_t;

  typedef struct packed {
    ptm_action_t        action;
    logic [VA_W-1:0]    virt_addr;
    logic [PA_W-1:0]    phys_addr;
    logic [ENTRY_W-1:0] map_flags;
  } ptm_req_t;

  typedef struct packed {
    ptm_status_t     status;
    logic [PA_W-1:0] translated_addr;
  } ptm_rsp_t;

  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] waddr;
    logic [ENTRY_W-1:0]  wdata;
    logic [STORE_AW-1:0] raddr;
  } ptm_mem_req_t;

endpackage

`default_nettype wire

@@ design/ptm_store.sv @@
// Table frame store: one write port and one read port with registered data.
// Depends on ptm_pkg for its depth and entry width.
`timescale 1ns / 1ps
`default_nettype none

module ptm_store
  import ptm_pkg::*;
(
  input  wire logic         clk,
  input  wire ptm_mem_req_t mem_req,
  output logic [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [0:STORE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[mem_req.raddr];
  end

endmodule

`default_nettype wire

@@ design/ptm_walker.sv @@
// Walk sequencer: one entry check unit reused per level, frame zeroing and
// bump allocation. Depends on ptm_pkg; drives the ptm_store ports.
`timescale 1ns / 1ps
`default_nettype none

module ptm_walker
  import ptm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  input  wire ptm_req_t           req_in,
  output logic                    req_ready,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output ptm_rsp_t                rsp,
  output ptm_mem_req_t            mem_req,
  input  wire logic [ENTRY_W-1:0] rdata
);

  ptm_state_t          state, state_next;
  ptm_req_t            req, req_next;
  logic [1:0]          level, level_next;
  logic [FRAME_W-1:0]  frame, frame_next;
  logic [IDX_W-1:0]    cnt, cnt_next;
  logic [NF_W-1:0]     nf, nf_next;
  ptm_status_t         status, status_next;
  logic [PA_W-1:0]     addr, addr_next;

  logic [IDX_W-1:0]    idx;
  logic [PFN_W-1:0]    child;
  logic                present;
  logic                child_ok;
  logic                nf_ok;
  logic [FRAME_W-1:0]  zero_frame;
  logic [ENTRY_W-1:0]  link_entry;
  logic [ENTRY_W-1:0]  leaf_entry;

  always_comb begin
    case (level)
      2'd3:    idx = req.virt_addr[47:39];
      2'd2:    idx = req.virt_addr[38:30];
      2'd1:    idx = req.virt_addr[29:21];
      default: idx = req.virt_addr[20:12];
    endcase
  end

  // Entry decode for the word read at the current level.
  assign present  = rdata[BIT_PRESENT];
  assign child    = rdata[PA_W-1:OFF_W];
  assign child_ok = child < PFN_W'(TABLE_FRAMES);
  assign nf_ok    = nf < NF_W'(TABLE_FRAMES);

  assign zero_frame = (state == ST_INIT) ? '0 : nf[FRAME_W-1:0];

  always_comb begin
    link_entry = '0;
    link_entry[PA_W-1:OFF_W] = PFN_W'(nf);
    link_entry[BIT_PRESENT]  = 1'b1;
    link_entry[BIT_WRITE]    = 1'b1;
    link_entry[BIT_USER]     = req.map_flags[BIT_USER];
  end

  always_comb begin
    leaf_entry = '0;
    leaf_entry[PA_W-1:OFF_W] = req.phys_addr[PA_W-1:OFF_W];
    leaf_entry = leaf_entry | req.map_flags;
    leaf_entry[BIT_PRESENT] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      cnt   <= '0;
      nf    <= NF_W'(1);
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      nf    <= nf_next;
    end
  end

  always_ff @(posedge clk) begin
    req    <= req_next;
    level  <= level_next;
    frame  <= frame_next;
    status <= status_next;
    addr   <= addr_next;
  end

  always_comb begin
    state_next  = state;
    req_next    = req;
    level_next  = level;
    frame_next  = frame;
    cnt_next    = cnt;
    nf_next     = nf;
    status_next = status;
    addr_next   = addr;
    mem_req       = '0;
    mem_req.raddr = {frame, idx};
    req_ready   = 1'b0;
    rsp_valid   = 1'b0;

    unique case (state)
      ST_INIT, ST_ZERO: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = {zero_frame, cnt};
        mem_req.wdata = '0;
        cnt_next      = cnt + IDX_W'(1);
        if (&cnt) begin
          state_next = (state == ST_INIT) ? ST_IDLE : ST_LINK;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          req_next    = req_in;
          level_next  = 2'd3;
          frame_next  = '0;
          status_next = STAT_OK;
          addr_next   = '0;
          state_next  = (req_in.action == ACT_NONE) ? ST_DONE : ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (level != 2'd0) begin
          if (present && child_ok) begin
            frame_next = child[FRAME_W-1:0];
            level_next = level - 2'd1;
            state_next = ST_READ;
          end else if (req.action == ACT_MAP) begin
            if (!present && nf_ok) begin
              cnt_next   = '0;
              state_next = ST_ZERO;
            end else begin
              status_next = STAT_NOMEM;
              state_next  = ST_DONE;
            end
          end else begin
            status_next = STAT_UNMAPPED;
            state_next  = ST_DONE;
          end
        end else begin
          state_next    = ST_DONE;
          mem_req.waddr = {frame, idx};
          case (req.action)
            ACT_MAP: begin
              if (present) begin
                status_next = STAT_MAPPED;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.wdata = leaf_entry;
              end
            end
            ACT_UNMAP: begin
              if (present) begin
                mem_req.we    = 1'b1;
                mem_req.wdata = '0;
              end else begin
                status_next = STAT_UNMAPPED;
              end
            end
            default: begin
              if (present) begin
                addr_next = {rdata[PA_W-1:OFF_W], req.virt_addr[OFF_W-1:0]};
              end else begin
                status_next = STAT_UNMAPPED;
              end
            end
          endcase
        end
      end
      ST_LINK: begin
        // The fresh frame is zero now; hook it into the parent slot.
        mem_req.we    = 1'b1;
        mem_req.waddr = {frame, idx};
        mem_req.wdata = link_entry;
        frame_next    = nf[FRAME_W-1:0];
        nf_next       = nf + NF_W'(1);
        level_next    = level - 2'd1;
        state_next    = ST_READ;
      end
      ST_DONE: begin
        rsp_valid = 1'b1;
        if (rsp_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign rsp.status          = status;
  assign rsp.translated_addr = addr;

endmodule

`default_nettype wire

@@ design/four_level_page_table_manager.sv @@
// Top level of the four-level page table manager: stream ports, output
// register, walk sequencer and frame store. Depends on ptm_pkg, ptm_walker, ptm_store.
//
// Channel  Direction  Fields (low bit first)
// s_axis   in         tuser: action; tdata: virt_addr, phys_addr, map_flags
// m_axis   out        tdata: status, translated_addr
//
// Unmap and translate do a read and a check for each of the four levels, then
// give the result. Map does the same and, for each new table frame, also zeroes
// the frame one entry a cycle through the single store write port, then links it in.
// After reset a pass clears the root frame; no item is accepted then.
// Input is taken only while the sequencer is idle; a result waits in the output
// register, and the sequencer holds its next result until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module four_level_page_table_manager
  import ptm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // virt_addr [47:0], phys_addr [99:48], map_flags [163:100], zero fill
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // action [1:0]
  input  wire logic [1:0]            s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // status [1:0], translated_addr [53:2], zero fill
  output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

  ptm_req_t           req_in;
  ptm_rsp_t           rsp;
  ptm_mem_req_t       mem_req;
  logic [ENTRY_W-1:0] rdata;
  logic               rsp_valid;
  logic               rsp_ready;
  logic               out_valid;
  ptm_rsp_t           out_rsp;

  assign req_in.action    = ptm_action_t'(s_axis_tuser);
  assign req_in.virt_addr = s_axis_tdata[47:0];
  assign req_in.phys_addr = s_axis_tdata[99:48];
  assign req_in.map_flags = s_axis_tdata[163:100];

  ptm_walker u_walker (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_axis_tvalid),
    .req_in    (req_in),
    .req_ready (s_axis_tready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .mem_req   (mem_req),
    .rdata     (rdata)
  );

  ptm_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rdata   (rdata)
  );

  assign rsp_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rsp_ready) begin
      out_valid <= rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_valid && rsp_ready) begin
      out_rsp <= rsp;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_rsp.translated_addr, out_rsp.status};

endmodule

`default_nettype wire

@@ design/ptm_checker.sv @@
// Port checker for the four-level page table manager, bound to the top level.
// Depends on ptm_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none

`include "four_level_page_table_manager_defines.svh"

module ptm_checker
  import ptm_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

  `PTM_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result item dropped while stalled")
  `PTM_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "stalled result item changed")
  `PTM_ASSERT(a_busy_after_accept, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "second item taken during a walk")
  `PTM_ASSERT(a_fail_no_addr, m_axis_tvalid && (m_axis_tdata[1:0] != STAT_OK) |-> (m_axis_tdata[53:2] == '0), "failed request carries an address")
  `PTM_ASSERT_ALWAYS(a_clear_after_reset, rst |=> !s_axis_tready, "item accepted before the root frame is cleared")

endmodule

bind four_level_page_table_manager ptm_checker u_ptm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
